// File: hw/rtl/fln_pkg.sv
// Shared types and constants for the force layout node step block.
// Used by the top level; the divider stands alone.
package fln_pkg;

  // Field widths
  localparam int POS_W       = 24;
  localparam int ACC_W       = 32;
  localparam int LINK_W      = 6;
  localparam int TDATA_IN_W  = 56;
  localparam int TDATA_OUT_W = 56;
  localparam int CFG_ADDR_W  = 2;

  // Force constants: 150 / 2.0 folded into one gain, weight per link, clamp margin
  localparam int REPEL_GAIN   = 75;
  localparam int WEIGHT_STEP  = 30;
  localparam int CLAMP_MARGIN = 10;

  // Request kinds carried on tuser
  typedef enum logic [1:0] {
    REQ_BEGIN   = 2'd0,
    REQ_REPEL   = 2'd1,
    REQ_ATTRACT = 2'd2,
    REQ_FINISH  = 2'd3
  } req_t;

  // Configuration register indexes
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_LEFT   = 2'd0,
    REG_RIGHT  = 2'd1,
    REG_TOP    = 2'd2,
    REG_BOTTOM = 2'd3
  } cfg_reg_t;

endpackage

// File: hw/rtl/fln_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Standalone; shared by the repulsion and attraction steps of the top level.
module fln_div #(
  parameter int DIVIDEND_W = 48,
  parameter int DIVISOR_W  = 49
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic                  done,
  output logic [DIVIDEND_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic                  busy;
  logic [CNT_W-1:0]      cnt;
  logic [DIVISOR_W-1:0]  rem;
  logic [DIVISOR_W-1:0]  den;
  logic [DIVIDEND_W-1:0] quo;

  logic [DIVISOR_W:0]    rem_sh;
  logic [DIVISOR_W+1:0]  diff;
  logic                  fits;

  // Shift in the next dividend bit and try the subtraction
  always_comb begin
    rem_sh = {rem, quo[DIVIDEND_W-1]};
    diff   = {1'b0, rem_sh} - {2'b00, den};
    fits   = ~diff[DIVISOR_W+1];
  end

  // Control: count the steps, pulse done after the last one
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= ~start & busy & (cnt == CNT_W'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DIVIDEND_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // Datapath: remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      den <= divisor;
      rem <= '0;
    end else if (busy) begin
      rem <= fits ? diff[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
      quo <= {quo[DIVIDEND_W-2:0], fits};
    end
  end

  assign quotient = quo;

endmodule

// File: hw/rtl/force_layout_node_step.sv
// Top level of the force layout node step: stream ports, sequencer,
// velocity accumulators and finish/clamp logic. Uses fln_pkg and fln_div.
//
// Usage: each transaction on the s_ channel is one request, its kind on
// s_tuser. A begin request loads the node's position, link count and held
// flag and clears the velocity. Repulsion requests (another node's position)
// and attraction requests (a linked neighbour's position) each add one force
// term. A finish request produces one transaction on the m_ channel with the
// clamped next position and a moved flag; other requests produce nothing.
// Scene edges are to be written on the cfg_ port only while the block is idle; the block does not enforce this.
// Begin, and repulsion from a node at the same spot, are handled in the idle
// state. Attraction and repulsion keep s_tready low while they run; repulsion
// first squares the offsets, and both use the one shared divider at one
// quotient bit per cycle, x then y. Finish passes through a sum and a clamp
// state and loads the output register in the clamp state once it is free.
// s_tready is high only while the sequencer is idle. A result waits in the
// output register until m_tready; further requests are still taken, and a
// following finish holds in its last step until the register is free.
// Reset (synchronous, rst high) clears the node state, sets the weight to 30
// and zeroes the scene edges; no transaction is pending after reset.
module force_layout_node_step
  import fln_pkg::*;
#(
  parameter int MAX_LINKS = 63,
  parameter int FRAC_BITS = 8
) (
  input  logic                    clk,
  input  logic                    rst,
  // Requests. tdata: pos_x[23:0], pos_y[47:24], link_count[53:48], held[54]
  input  logic                    s_tvalid,
  output logic                    s_tready,
  input  logic [TDATA_IN_W-1:0]   s_tdata,
  // tuser: req_type[1:0]
  input  logic [1:0]              s_tuser,
  // Results. tdata: new_x[23:0], new_y[47:24], moved[48]
  output logic                    m_tvalid,
  input  logic                    m_tready,
  output logic [TDATA_OUT_W-1:0]  m_tdata,
  // Configuration write port
  input  logic                    cfg_we,
  input  logic [CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [POS_W-1:0]        cfg_wdata
);

  // Derived widths and constants
  localparam int MAG_W     = POS_W;
  localparam int SQ_W      = 2 * MAG_W;
  localparam int SUM_W     = SQ_W + 1;
  localparam int NUM_W     = MAG_W + 7 + 2 * FRAC_BITS;
  localparam int TERM_W    = 34;
  localparam int ACCX_W    = ACC_W + 4;
  localparam int CL_W      = ACC_W + 2;
  localparam int LINK_CAP  = (MAX_LINKS < 63) ? MAX_LINKS : 63;
  localparam int WEIGHT_W  = $clog2((LINK_CAP + 1) * WEIGHT_STEP + 1);
  localparam int THR       = ((1 << FRAC_BITS) + 9) / 10;

  localparam logic [LINK_W-1:0]          LINK_CAP_V = LINK_W'(LINK_CAP);
  localparam logic [NUM_W-1:0]           Q_LIMIT = {{(NUM_W-TERM_W){1'b0}}, 1'b1,
                                                    {(TERM_W-1){1'b0}}};
  localparam logic signed [ACC_W-1:0]    THR_S = ACC_W'(THR);
  localparam logic signed [ACC_W-1:0]    NEG_THR_S = -THR_S;
  localparam logic signed [CL_W-1:0]     MARGIN = CL_W'(CLAMP_MARGIN << FRAC_BITS);
  localparam logic signed [CL_W-1:0]     POS_MAX_E = {{(CL_W-POS_W+1){1'b0}},
                                                      {(POS_W-1){1'b1}}};
  localparam logic signed [CL_W-1:0]     POS_MIN_E = {{(CL_W-POS_W+1){1'b1}},
                                                      {(POS_W-1){1'b0}}};
  localparam logic signed [ACCX_W-1:0]   ACC_MAX_W = {{(ACCX_W-ACC_W+1){1'b0}},
                                                      {(ACC_W-1){1'b1}}};
  localparam logic signed [ACCX_W-1:0]   ACC_MIN_W = {{(ACCX_W-ACC_W+1){1'b1}},
                                                      {(ACC_W-1){1'b0}}};

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_SQX    = 9'b000000010,
    ST_SQY    = 9'b000000100,
    ST_REPX   = 9'b000001000,
    ST_REPY   = 9'b000010000,
    ST_ATTX   = 9'b000100000,
    ST_ATTY   = 9'b001000000,
    ST_FSUM   = 9'b010000000,
    ST_FCLAMP = 9'b100000000
  } state_t;

  state_t state;

  // Node state and configuration
  logic signed [POS_W-1:0] own_x, own_y;
  logic signed [ACC_W-1:0] vel_x, vel_y;
  logic [WEIGHT_W-1:0]     weight;
  logic                    is_held;
  logic signed [POS_W-1:0] rect_left, rect_right, rect_top, rect_bottom;

  // Per-request working registers
  logic [MAG_W-1:0]        mag_dx, mag_dy;
  logic                    neg_dx, neg_dy;
  logic [SQ_W-1:0]         sq_x, sq_y;
  logic                    div_go;
  logic signed [CL_W-1:0]  sum_x, lo_x, hi_x, sum_y, lo_y, hi_y;

  // Output register
  logic signed [POS_W-1:0] new_x, new_y;
  logic                    moved;

  // Input unpacking
  req_t                    in_type;
  logic signed [POS_W-1:0] in_px, in_py;
  logic [LINK_W-1:0]       in_links;
  logic                    in_held;
  logic                    in_acc;

  assign in_type  = req_t'(s_tuser);
  assign in_px    = signed'(s_tdata[POS_W-1:0]);
  assign in_py    = signed'(s_tdata[2*POS_W-1:POS_W]);
  assign in_links = s_tdata[2*POS_W+LINK_W-1:2*POS_W];
  assign in_held  = s_tdata[2*POS_W+LINK_W];
  assign s_tready = (state == ST_IDLE);
  assign in_acc   = s_tvalid & s_tready;

  // Offsets to the other node, as magnitude and sign
  logic signed [POS_W:0] dx_in, dy_in;
  logic [MAG_W-1:0]      mag_dx_in, mag_dy_in;
  logic [LINK_W-1:0]     links_sat;
  logic [WEIGHT_W-1:0]   weight_in;

  always_comb begin
    dx_in     = (POS_W+1)'(own_x) - (POS_W+1)'(in_px);
    dy_in     = (POS_W+1)'(own_y) - (POS_W+1)'(in_py);
    mag_dx_in = dx_in[POS_W] ? MAG_W'(-dx_in) : MAG_W'(dx_in);
    mag_dy_in = dy_in[POS_W] ? MAG_W'(-dy_in) : MAG_W'(dy_in);
    links_sat = (in_links > LINK_CAP_V) ? LINK_CAP_V : in_links;
    weight_in = WEIGHT_W'((WEIGHT_W'(links_sat) + WEIGHT_W'(1)) * WEIGHT_W'(WEIGHT_STEP));
  end

  // Shared squaring multiplier
  logic [MAG_W-1:0] mul_a;
  logic [SQ_W-1:0]  sq_prod;

  assign mul_a   = (state == ST_SQX) ? mag_dx : mag_dy;
  assign sq_prod = SQ_W'(mul_a) * SQ_W'(mul_a);

  // Divider operand selection
  logic             axis_x, attract;
  logic [MAG_W-1:0] mag_sel;
  logic             neg_sel;
  logic [NUM_W-1:0] div_num;
  logic [SUM_W-1:0] div_den;
  logic             div_done;
  logic [NUM_W-1:0] div_quo;

  always_comb begin
    axis_x  = (state == ST_REPX) || (state == ST_ATTX);
    attract = (state == ST_ATTX) || (state == ST_ATTY);
    mag_sel = axis_x ? mag_dx : mag_dy;
    neg_sel = axis_x ? neg_dx : neg_dy;
    if (attract) begin
      div_num = NUM_W'(mag_sel);
      div_den = SUM_W'(weight);
    end else begin
      div_num = (NUM_W'(mag_sel) * NUM_W'(REPEL_GAIN)) << (2 * FRAC_BITS);
      div_den = SUM_W'(sq_x) + SUM_W'(sq_y);
    end
  end

  fln_div #(
    .DIVIDEND_W (NUM_W),
    .DIVISOR_W  (SUM_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_go),
    .dividend (div_num),
    .divisor  (div_den),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Saturating accumulate of the signed force term
  logic [TERM_W-1:0]        term_mag;
  logic signed [ACCX_W-1:0] acc_wide, term_wide, acc_res;
  logic signed [ACC_W-1:0]  acc_new;

  always_comb begin
    term_mag  = (div_quo > Q_LIMIT) ? TERM_W'(Q_LIMIT) : div_quo[TERM_W-1:0];
    acc_wide  = ACCX_W'(axis_x ? vel_x : vel_y);
    term_wide = signed'({{(ACCX_W-TERM_W){1'b0}}, term_mag});
    acc_res   = (neg_sel ^ attract) ? acc_wide - term_wide : acc_wide + term_wide;
    if (acc_res > ACC_MAX_W) begin
      acc_new = ACC_MAX_W[ACC_W-1:0];
    end else if (acc_res < ACC_MIN_W) begin
      acc_new = ACC_MIN_W[ACC_W-1:0];
    end else begin
      acc_new = acc_res[ACC_W-1:0];
    end
  end

  // Finish: snap small velocity, then clamp inside the scene; a held node keeps its position
  logic                    vel_small;
  logic signed [ACC_W-1:0] vx_use, vy_use;
  logic signed [POS_W-1:0] nx, ny;
  logic                    out_free;

  function automatic logic signed [POS_W-1:0] clamp_axis(
    input logic signed [CL_W-1:0] p,
    input logic signed [CL_W-1:0] lo,
    input logic signed [CL_W-1:0] hi
  );
    logic signed [CL_W-1:0] v;
    v = p;
    if (v < lo) v = lo;
    if (v > hi) v = hi;
    if (v > POS_MAX_E) v = POS_MAX_E;
    else if (v < POS_MIN_E) v = POS_MIN_E;
    return v[POS_W-1:0];
  endfunction

  always_comb begin
    vel_small = (vel_x > NEG_THR_S) && (vel_x < THR_S) &&
                (vel_y > NEG_THR_S) && (vel_y < THR_S);
    vx_use    = vel_small ? '0 : vel_x;
    vy_use    = vel_small ? '0 : vel_y;
    if (is_held) begin
      nx = own_x;
      ny = own_y;
    end else begin
      nx = clamp_axis(sum_x, lo_x, hi_x);
      ny = clamp_axis(sum_y, lo_y, hi_y);
    end
    out_free = ~m_tvalid | m_tready;
  end

  // Divider start and result valid for the next cycle
  logic div_go_next;
  logic m_tvalid_next;

  always_comb begin
    div_go_next   = (in_acc && (in_type == REQ_ATTRACT)) ||
                    (state == ST_SQY) ||
                    (state == ST_REPX && div_done) ||
                    (state == ST_ATTX && div_done);
    m_tvalid_next = (state == ST_FCLAMP && out_free) || (m_tvalid && !m_tready);
  end

  // Sequencer and state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      div_go      <= 1'b0;
      m_tvalid    <= 1'b0;
      own_x       <= '0;
      own_y       <= '0;
      vel_x       <= '0;
      vel_y       <= '0;
      weight      <= WEIGHT_W'(WEIGHT_STEP);
      is_held     <= 1'b0;
      rect_left   <= '0;
      rect_right  <= '0;
      rect_top    <= '0;
      rect_bottom <= '0;
    end else begin
      div_go   <= div_go_next;
      m_tvalid <= m_tvalid_next;

      // Configuration writes
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_addr))
          REG_LEFT:   rect_left   <= signed'(cfg_wdata);
          REG_RIGHT:  rect_right  <= signed'(cfg_wdata);
          REG_TOP:    rect_top    <= signed'(cfg_wdata);
          REG_BOTTOM: rect_bottom <= signed'(cfg_wdata);
          default: ;
        endcase
      end

      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            case (in_type)
              REQ_BEGIN: begin
                own_x   <= in_px;
                own_y   <= in_py;
                is_held <= in_held;
                vel_x   <= '0;
                vel_y   <= '0;
                weight  <= weight_in;
              end
              REQ_REPEL: begin
                // Skip a node at the same spot
                if (dx_in != '0 || dy_in != '0) begin
                  state <= ST_SQX;
                end
              end
              REQ_ATTRACT: begin
                state <= ST_ATTX;
              end
              REQ_FINISH: begin
                state <= ST_FSUM;
              end
              default: ;
            endcase
          end
        end
        ST_SQX: begin
          state <= ST_SQY;
        end
        ST_SQY: begin
          state <= ST_REPX;
        end
        ST_REPX: begin
          if (div_done) begin
            vel_x <= acc_new;
            state <= ST_REPY;
          end
        end
        ST_REPY: begin
          if (div_done) begin
            vel_y <= acc_new;
            state <= ST_IDLE;
          end
        end
        ST_ATTX: begin
          if (div_done) begin
            vel_x <= acc_new;
            state <= ST_ATTY;
          end
        end
        ST_ATTY: begin
          if (div_done) begin
            vel_y <= acc_new;
            state <= ST_IDLE;
          end
        end
        ST_FSUM: begin
          state <= ST_FCLAMP;
        end
        ST_FCLAMP: begin
          // Hold until the output register is free
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Working registers without reset
  always_ff @(posedge clk) begin
    if (in_acc) begin
      mag_dx <= mag_dx_in;
      mag_dy <= mag_dy_in;
      neg_dx <= dx_in[POS_W];
      neg_dy <= dy_in[POS_W];
    end
    if (state == ST_SQX) begin
      sq_x <= sq_prod;
    end
    if (state == ST_SQY) begin
      sq_y <= sq_prod;
    end
    if (state == ST_FSUM) begin
      sum_x <= CL_W'(own_x) + CL_W'(vx_use);
      sum_y <= CL_W'(own_y) + CL_W'(vy_use);
      lo_x  <= CL_W'(rect_left) + MARGIN;
      hi_x  <= CL_W'(rect_right) - MARGIN;
      lo_y  <= CL_W'(rect_top) + MARGIN;
      hi_y  <= CL_W'(rect_bottom) - MARGIN;
    end
    if (state == ST_FCLAMP && out_free) begin
      new_x <= nx;
      new_y <= ny;
      moved <= (nx != own_x) || (ny != own_y);
    end
  end

  assign m_tdata = {{(TDATA_OUT_W-2*POS_W-1){1'b0}}, moved, new_y, new_x};

endmodule
